// ===== rtl/sha1_pkg.sv =====
// Shared types, constants and round functions for the SHA-1 stream hasher.
// No dependencies; imported by every module of the block.
package sha1_pkg;

    localparam int ROUNDS = 80;

    localparam logic       ACT_ABSORB = 1'b0;
    localparam logic       ACT_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] BLOCK_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd4;

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    typedef struct packed {
        logic load;       // copy hash words into the working variables
        logic round;      // run one round
        logic final_add;  // fold working variables into the hash words
        logic init;       // return hash words to the initial values
    } t_core_ctl;

    function automatic logic [31:0] f_iv(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hEFCDAB89;
            3'd2:    v = 32'h98BADCFE;
            3'd3:    v = 32'h10325476;
            default: v = 32'hC3D2E1F0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] f_round_f(input logic [6:0] t, input logic [31:0] b,
                                              input logic [31:0] c, input logic [31:0] d);
        logic [31:0] v;
        if (t < 7'd20) begin
            v = (b & c) | (~b & d);
        end else if (t < 7'd40) begin
            v = b ^ c ^ d;
        end else if (t < 7'd60) begin
            v = (b & c) | (b & d) | (c & d);
        end else begin
            v = b ^ c ^ d;
        end
        return v;
    endfunction

    function automatic logic [31:0] f_round_k(input logic [6:0] t);
        logic [31:0] v;
        if (t < 7'd20) begin
            v = K_0;
        end else if (t < 7'd40) begin
            v = K_1;
        end else if (t < 7'd60) begin
            v = K_2;
        end else begin
            v = K_3;
        end
        return v;
    endfunction

endpackage

// ===== rtl/sha1_sched.sv =====
// Byte packer and message schedule: a 16-word shift line that is filled
// big-endian from bytes and then expands W[t] one word per round.
// Depends on sha1_pkg.
module sha1_sched
    import sha1_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_byte_valid,
    input  logic [7:0]  i_byte,
    input  logic [1:0]  i_pos_lo,
    input  logic        i_round,
    output logic [31:0] o_w
);

    logic [23:0] r_acc;
    logic [31:0] r_sh [16];
    logic [31:0] s_x;
    logic [31:0] s_next;

    // Position 0 holds W[t]; position k holds W[t+k].
    assign s_x    = r_sh[13] ^ r_sh[8] ^ r_sh[2] ^ r_sh[0];
    assign s_next = {s_x[30:0], s_x[31]};
    assign o_w    = r_sh[0];

    always_ff @(posedge i_clk) begin
        if (i_byte_valid) begin
            r_acc <= {r_acc[15:0], i_byte};
        end
        if (i_byte_valid && i_pos_lo == 2'd3) begin
            for (int i = 0; i < 15; i++) begin
                r_sh[i] <= r_sh[i + 1];
            end
            r_sh[15] <= {r_acc, i_byte};
        end else if (i_round) begin
            for (int i = 0; i < 15; i++) begin
                r_sh[i] <= r_sh[i + 1];
            end
            r_sh[15] <= s_next;
        end
    end

endmodule

// ===== rtl/sha1_core.sv =====
// Shared SHA-1 round unit: working variables a..e, one round per cycle,
// and the five hash words with their final add. Depends on sha1_pkg.
module sha1_core
    import sha1_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_core_ctl   i_ctl,
    input  logic [6:0]  i_t,
    input  logic [31:0] i_w,
    input  logic [2:0]  i_rd_idx,
    output logic [31:0] o_hash_word
);

    logic [31:0] r_h [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] s_t;

    assign s_t = {r_a[26:0], r_a[31:27]} + f_round_f(i_t, r_b, r_c, r_d)
               + r_e + f_round_k(i_t) + i_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            for (int i = 0; i < 5; i++) begin
                r_h[i] <= f_iv(3'(i));
            end
        end else if (i_ctl.final_add) begin
            r_h[0] <= r_h[0] + r_a;
            r_h[1] <= r_h[1] + r_b;
            r_h[2] <= r_h[2] + r_c;
            r_h[3] <= r_h[3] + r_d;
            r_h[4] <= r_h[4] + r_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_ctl.round) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= s_t;
        end
    end

    always_comb begin
        case (i_rd_idx)
            3'd0:    o_hash_word = r_h[0];
            3'd1:    o_hash_word = r_h[1];
            3'd2:    o_hash_word = r_h[2];
            3'd3:    o_hash_word = r_h[3];
            3'd4:    o_hash_word = r_h[4];
            default: o_hash_word = '0;
        endcase
    end

endmodule

// ===== rtl/sha1_stream_hasher.sv =====
// SHA-1 stream hasher top level: handshakes, padding sequencer and digest output.
// Depends on sha1_pkg, sha1_sched and sha1_core.
//
// Input items arrive on the slave stream: tuser is the action (0 absorb,
// 1 finish) and tdata the message byte. An absorb item stores its byte,
// and the 64th byte of a block also starts a compression: 80 rounds
// on the shared round unit, one per cycle, followed by the final
// add, during which tready stays low. A finish item injects the 0x80
// marker and zero bytes one per cycle up to byte 56 (through an extra
// compressed block when 56 or more bytes were pending), then the eight
// length bytes, then compresses the last block. The digest follows on the
// master stream as five items, word 0 first, with tuser the word index and
// tlast on the fifth. A stalled receiver holds the current word; no new
// item is taken until the fifth word is accepted, at which point the hash
// words, length and fill count return to their initial values.
// Reset is synchronous and active low and gives the same state as that
// return; the block is ready in the first cycle after reset.
module sha1_stream_hasher
    import sha1_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] digest_word
    output logic [2:0]  o_m_tuser,   // [2:0] word_index
    output logic        o_m_tlast
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_FINAL = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_LEN   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_ret, n_ret;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bits, n_bits;
    logic        r_first, n_first;
    logic [6:0]  r_cnt, n_cnt;

    logic        s_accept;
    logic        s_inj_valid;
    logic [7:0]  s_inj_byte;
    t_core_ctl   s_ctl;
    logic [31:0] s_w;
    logic [31:0] s_hash_word;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_fill      = r_fill;
        n_bits      = r_bits;
        n_first     = r_first;
        n_cnt       = r_cnt;
        s_inj_valid = 1'b0;
        s_inj_byte  = i_s_tdata;
        s_ctl       = '0;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    if (i_s_tuser == ACT_FINISH) begin
                        n_state = ST_PAD;
                        n_first = 1'b1;
                    end else begin
                        s_inj_valid = 1'b1;
                        n_bits      = r_bits + 64'd8;
                        if (r_fill == BLOCK_LAST) begin
                            n_state   = ST_ROUND;
                            n_ret     = ST_IDLE;
                            n_cnt     = '0;
                            s_ctl.load = 1'b1;
                        end
                    end
                end
            end
            ST_PAD: begin
                if (r_fill == LEN_POS && !r_first) begin
                    n_state = ST_LEN;
                    n_cnt   = '0;
                end else begin
                    s_inj_valid = 1'b1;
                    s_inj_byte  = r_first ? PAD_BYTE : 8'h00;
                    n_first     = 1'b0;
                    if (r_fill == BLOCK_LAST) begin
                        n_state    = ST_ROUND;
                        n_ret      = ST_PAD;
                        n_cnt      = '0;
                        s_ctl.load = 1'b1;
                    end
                end
            end
            ST_LEN: begin
                // Length goes out most significant byte first.
                s_inj_valid = 1'b1;
                s_inj_byte  = r_bits[{~r_cnt[2:0], 3'b000} +: 8];
                n_cnt       = r_cnt + 7'd1;
                if (r_cnt[2:0] == 3'd7) begin
                    n_state    = ST_ROUND;
                    n_ret      = ST_OUT;
                    n_cnt      = '0;
                    s_ctl.load = 1'b1;
                end
            end
            ST_ROUND: begin
                s_ctl.round = 1'b1;
                n_cnt       = r_cnt + 7'd1;
                if (r_cnt == 7'(ROUNDS - 1)) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                s_ctl.final_add = 1'b1;
                n_state         = r_ret;
                n_cnt           = '0;
            end
            ST_OUT: begin
                if (i_m_tready) begin
                    n_cnt = r_cnt + 7'd1;
                    if (r_cnt[2:0] == WORD_LAST) begin
                        n_state    = ST_IDLE;
                        n_bits     = '0;
                        n_fill     = '0;
                        s_ctl.init = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (s_inj_valid) begin
            n_fill = r_fill + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_fill  <= '0;
            r_bits  <= '0;
            r_first <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fill  <= n_fill;
            r_bits  <= n_bits;
            r_first <= n_first;
            r_cnt   <= n_cnt;
        end
    end

    sha1_sched u_sched (
        .i_clk        (i_clk),
        .i_byte_valid (s_inj_valid),
        .i_byte       (s_inj_byte),
        .i_pos_lo     (r_fill[1:0]),
        .i_round      (s_ctl.round),
        .o_w          (s_w)
    );

    sha1_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (s_ctl),
        .i_t         (r_cnt),
        .i_w         (s_w),
        .i_rd_idx    (r_cnt[2:0]),
        .o_hash_word (s_hash_word)
    );

    assign o_m_tvalid = (r_state == ST_OUT);
    assign o_m_tdata  = s_hash_word;
    assign o_m_tuser  = r_cnt[2:0];
    assign o_m_tlast  = (r_cnt[2:0] == WORD_LAST);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while digest words are pending");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_cnt < 7'(ROUNDS)))
        else $error("round counter past the last round");

    a_len_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LEN && r_cnt == 7'd0) |-> (r_fill == LEN_POS))
        else $error("length bytes not placed at byte 56");

    a_out_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_cnt <= 7'(WORD_LAST)))
        else $error("digest word index out of range");

    a_ready_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> (o_s_tready && r_fill == 6'd0))
        else $error("block not idle and empty after the last digest word");

endmodule
